[design/ttab_pkg.sv]
// Shared types, codes and constants of the tick timebase and alarm bank.
// Used by every module in the design folder; depends on nothing.
package ttab_pkg;

	localparam int NUM_ALARMS = 4;
	localparam int NUM_JOBS   = 4;
	localparam int US_PER_MS  = 1000;
	localparam int MS_PER_S   = 1000;

	localparam int ACTION_W = 3;
	localparam int ID_W     = 3;
	localparam int DUR_W    = 32;
	localparam int STATUS_W = 2;
	localparam int FIRED_W  = 4;
	localparam int SEC_W    = 32;
	localparam int MS_W     = 10;
	localparam int SUB_W    = 11;
	localparam int TICK_W   = 10;
	localparam int DATA_W   = 32;
	localparam int CFG_IW   = 3;
	localparam int ALARM_IW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_ARM_MS = 3'd1,
		ACT_ARM_S  = 3'd2,
		ACT_CHECK  = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_RANG   = 2'd0,
		ST_WAIT   = 2'd1,
		ST_BAD_ID = 2'd2,
		ST_NONE   = 2'd3
	} status_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_TICK_PERIOD = 3'd0,
		REG_JOB_PERIOD0 = 3'd1
	} reg_idx_t;

	// One decoded request, already qualified by the pipeline advancing.
	typedef struct packed {
		logic              tick;
		logic              arm;
		logic              arm_sec;
		logic              check;
		logic              clear;
		logic [ID_W-1:0]   slot_sel;
		logic [DUR_W-1:0]  duration;
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [CFG_IW-1:0] index;
		logic [DATA_W-1:0] data;
	} cfg_wr_t;

	// Tick periods above one millisecond count as one millisecond.
	function automatic logic [TICK_W-1:0] clamp_step(input logic [TICK_W-1:0] period);
		if (period > TICK_W'(US_PER_MS)) begin
			return TICK_W'(US_PER_MS);
		end
		return period;
	endfunction

endpackage

[design/ttab_timebase.sv]
// Sub-millisecond accumulator, millisecond and seconds counters, and a
// running 32-bit millisecond count. Depends on ttab_pkg.
module ttab_timebase (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ttab_pkg::cmd_t                cmd,
	input  logic [ttab_pkg::TICK_W-1:0]   step,
	output logic [ttab_pkg::SEC_W-1:0]    seconds_next,
	output logic [ttab_pkg::MS_W-1:0]     millis_next,
	output logic [31:0]                   now_ms
);

	logic [ttab_pkg::SUB_W-1:0] sub_q, sub_nx, sub_sum;
	logic [ttab_pkg::MS_W-1:0]  ms_q;
	logic [ttab_pkg::SEC_W-1:0] sec_q;
	logic [31:0]                now_q, now_nx;
	logic                       carry, ms_wrap;

	always_comb begin
		sub_sum = sub_q + ttab_pkg::SUB_W'(step);
		carry   = sub_sum >= ttab_pkg::SUB_W'(ttab_pkg::US_PER_MS);
		ms_wrap = carry && (ms_q == ttab_pkg::MS_W'(ttab_pkg::MS_PER_S - 1));
		sub_nx       = sub_q;
		millis_next  = ms_q;
		seconds_next = sec_q;
		now_nx       = now_q;
		if (cmd.tick) begin
			sub_nx = carry ? sub_sum - ttab_pkg::SUB_W'(ttab_pkg::US_PER_MS) : sub_sum;
			if (ms_wrap) begin
				millis_next  = '0;
				seconds_next = sec_q + 1'b1;
			end else begin
				millis_next = ms_q + ttab_pkg::MS_W'(carry);
			end
			now_nx = now_q + 32'(carry);
		end else if (cmd.clear) begin
			sub_nx       = '0;
			millis_next  = '0;
			seconds_next = '0;
			now_nx       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= '0;
			ms_q  <= '0;
			sec_q <= '0;
			now_q <= '0;
		end else begin
			sub_q <= sub_nx;
			ms_q  <= millis_next;
			sec_q <= seconds_next;
			now_q <= now_nx;
		end
	end

	// seconds*1000 + millis modulo 2^32, kept as a counter of its own.
	assign now_ms = now_q;

endmodule

[design/ttab_jobs.sv]
// Periodic job slots: period registers, saturating accumulators and the
// fired mask of one tick. Depends on ttab_pkg.
module ttab_jobs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ttab_pkg::cmd_t                    cmd,
	input  ttab_pkg::cfg_wr_t                 cfg,
	input  logic [ttab_pkg::TICK_W-1:0]       step,
	output logic [ttab_pkg::NUM_JOBS-1:0]     fired
);

	logic [31:0] period_q [ttab_pkg::NUM_JOBS];
	logic [31:0] acc_q    [ttab_pkg::NUM_JOBS];

	for (genvar k = 0; k < ttab_pkg::NUM_JOBS; k++) begin : g_slot
		localparam logic [ttab_pkg::CFG_IW-1:0] SlotIdx =
			ttab_pkg::CFG_IW'(int'(ttab_pkg::REG_JOB_PERIOD0) + k);

		logic [32:0] sum;
		logic [31:0] sat;
		logic        enabled;
		logic        fire;

		always_comb begin
			sum     = {1'b0, acc_q[k]} + 33'(step);
			sat     = sum[32] ? '1 : sum[31:0];
			enabled = period_q[k] != '0;
			fire    = cmd.tick && enabled && (sat >= period_q[k]);
		end

		assign fired[k] = fire;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				period_q[k] <= '0;
				acc_q[k]    <= '0;
			end else if (cfg.we && cfg.index == SlotIdx) begin
				period_q[k] <= cfg.data;
				acc_q[k]    <= '0;
			end else if (cmd.tick && enabled) begin
				acc_q[k] <= fire ? '0 : sat;
			end
		end
	end

endmodule

[design/ttab_alarms.sv]
// One-shot alarm bank: arm by milliseconds or seconds, check and disarm.
// Depends on ttab_pkg; takes the running millisecond count from the timebase.
module ttab_alarms (
	input  logic              clk,
	input  logic              arst_n,
	input  ttab_pkg::cmd_t    cmd,
	input  logic [31:0]       now_ms,
	output ttab_pkg::status_t status
);

	logic                          armed_q [ttab_pkg::NUM_ALARMS];
	logic [31:0]                   len_q   [ttab_pkg::NUM_ALARMS];
	logic [31:0]                   start_q [ttab_pkg::NUM_ALARMS];
	logic [ttab_pkg::ALARM_IW-1:0] idx;
	logic                          bad_id, rang;
	logic [31:0]                   len_sec, elapsed;

	always_comb begin
		bad_id  = {1'b0, cmd.slot_sel} >= (ttab_pkg::ID_W + 1)'(ttab_pkg::NUM_ALARMS);
		idx     = ttab_pkg::ALARM_IW'(cmd.slot_sel);
		len_sec = cmd.duration * 32'(ttab_pkg::MS_PER_S);
		elapsed = now_ms - start_q[idx];
		rang    = armed_q[idx] && (elapsed >= len_q[idx]);
		if (bad_id) begin
			status = ttab_pkg::ST_BAD_ID;
		end else if (rang) begin
			status = ttab_pkg::ST_RANG;
		end else begin
			status = ttab_pkg::ST_WAIT;
		end
	end

	for (genvar a = 0; a < ttab_pkg::NUM_ALARMS; a++) begin : g_alarm
		logic sel;
		assign sel = !bad_id && (idx == ttab_pkg::ALARM_IW'(a));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				armed_q[a] <= 1'b0;
				len_q[a]   <= '0;
				start_q[a] <= '0;
			end else if (cmd.arm && sel) begin
				armed_q[a] <= 1'b1;
				len_q[a]   <= cmd.arm_sec ? len_sec : cmd.duration;
				start_q[a] <= now_ms;
			end else if (cmd.check && sel && rang) begin
				armed_q[a] <= 1'b0;
			end
		end
	end

endmodule

[design/tick_timebase_alarm_bank_unit.sv]
// Tick timebase with one-shot alarms and periodic job slots, top level.
// A request passes through the input register and the result register to the master side.
// Throughput: one request per cycle unless m_tready stalls; all updates run as requests advance.
// Reset (arst_n low) clears all counters, alarms and job slots and sets the tick period to 1000.
// Depends on ttab_pkg, ttab_timebase, ttab_jobs and ttab_alarms.
module tick_timebase_alarm_bank_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ttab_pkg::S_TDATA_W-1:0]     s_tdata,  // slot_sel[2:0], duration[34:3], zero fill
	input  logic [ttab_pkg::ACTION_W-1:0]      s_tuser,  // action[2:0]
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ttab_pkg::M_TDATA_W-1:0]     m_tdata,  // alarm_status[1:0], fired_jobs[5:2],
	                                                     // seconds_now[37:6], millis_now[47:38]
	// Register write port.
	input  logic                               cfg_we,
	input  logic [ttab_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [ttab_pkg::DATA_W-1:0]        cfg_data
);

	// Input register stage.
	logic                             valid_s1;
	ttab_pkg::action_t                action_s1;
	logic [ttab_pkg::ID_W-1:0]        id_s1;
	logic [ttab_pkg::DUR_W-1:0]       dur_s1;

	// Result register stage.
	logic                             valid_s2;
	ttab_pkg::status_t                status_s2;
	logic [ttab_pkg::FIRED_W-1:0]     fired_s2;
	logic [ttab_pkg::SEC_W-1:0]       sec_s2;
	logic [ttab_pkg::MS_W-1:0]        ms_s2;

	logic [ttab_pkg::TICK_W-1:0]      tick_period_q;
	logic [ttab_pkg::TICK_W-1:0]      step;
	logic                             advance;
	ttab_pkg::cmd_t                   cmd;
	ttab_pkg::cfg_wr_t                cfg;
	logic [ttab_pkg::SEC_W-1:0]       seconds_next;
	logic [ttab_pkg::MS_W-1:0]        millis_next;
	logic [31:0]                      now_ms;
	logic [ttab_pkg::NUM_JOBS-1:0]    fired;
	ttab_pkg::status_t                alarm_status;

	// The held request moves on whenever the result register is empty or
	// is being drained this cycle, so a waiting result never blocks intake
	// for more than the one request sitting in the input register.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= ttab_pkg::action_t'(s_tuser);
			id_s1     <= s_tdata[ttab_pkg::ID_W-1:0];
			dur_s1    <= s_tdata[ttab_pkg::ID_W +: ttab_pkg::DUR_W];
		end
	end

	// Decode the held request into one-hot strobes that only fire on the
	// cycle it is processed. Unused action codes decode to nothing.
	always_comb begin
		cmd          = '0;
		cmd.slot_sel = id_s1;
		cmd.duration = dur_s1;
		unique case (action_s1)
			ttab_pkg::ACT_TICK:   cmd.tick  = advance;
			ttab_pkg::ACT_ARM_MS: cmd.arm   = advance;
			ttab_pkg::ACT_ARM_S: begin
				cmd.arm     = advance;
				cmd.arm_sec = 1'b1;
			end
			ttab_pkg::ACT_CHECK:  cmd.check = advance;
			ttab_pkg::ACT_CLEAR:  cmd.clear = advance;
			default: ;
		endcase
	end

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_period_q <= ttab_pkg::TICK_W'(ttab_pkg::US_PER_MS);
		end else if (cfg_we && cfg_index == ttab_pkg::REG_TICK_PERIOD) begin
			tick_period_q <= cfg_data[ttab_pkg::TICK_W-1:0];
		end
	end

	assign step = ttab_pkg::clamp_step(tick_period_q);

	ttab_timebase u_timebase (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.step         (step),
		.seconds_next (seconds_next),
		.millis_next  (millis_next),
		.now_ms       (now_ms)
	);

	ttab_jobs u_jobs (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.step   (step),
		.fired  (fired)
	);

	ttab_alarms u_alarms (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.now_ms (now_ms),
		.status (alarm_status)
	);

	// Result register: the status is only meaningful for a check, the
	// fired mask only for a tick (the job unit already gates it).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= cmd.check ? alarm_status : ttab_pkg::ST_NONE;
			fired_s2  <= ttab_pkg::FIRED_W'(fired);
			sec_s2    <= seconds_next;
			ms_s2     <= millis_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {ms_s2, sec_s2, fired_s2, status_s2};

endmodule
